@@ src/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ src/spk_pkg.sv @@
// constants and types for the speck64/128 bit-serial core
// no dependencies
`timescale 1ns / 1ps
package spk_pkg;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ROUNDS   = 27;
  localparam int unsigned BIT_W    = $clog2(WORD_W);
  localparam int unsigned RND_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [WORD_W-1:0] word_t;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } cfg_reg_t;
  typedef struct packed {
    logic load;
    logic step;
  } rnd_ctl_t;
endpackage

@@ src/speck64_128_encrypt_unit.sv @@
// speck64/128 encryption core, computed with bit-serial rounds
// depends on spk_pkg, spk_add_serial, assert_macros.svh
//
// channel  ports                               direction
// in       start, busy, in_plain_word_0/1      in (busy is out)
// out      out_valid, out_cipher_word_0/1      out
// cfg      cfg_we, cfg_index, cfg_data         in
//
// a block runs through ROUNDS rounds, each S_ADD then S_MIX, from accept to out_valid
// each round is one add pass over the WORD_W bits of each word through a single bit-serial adder pair
// followed by the rotate-xor in S_MIX; result strobes out_valid for one cycle
// busy drops with out_valid; a new block is taken only while busy is low
// reset clears the control state and the key registers; no stall on the output
`timescale 1ns / 1ps
`include "assert_macros.svh"
module speck64_128_encrypt_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  spk_pkg::word_t                in_plain_word_0,
  input  spk_pkg::word_t                in_plain_word_1,
  output logic                          out_valid,
  output spk_pkg::word_t                out_cipher_word_0,
  output spk_pkg::word_t                out_cipher_word_1,
  input  logic                          cfg_we,
  input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  spk_pkg::word_t                cfg_data
);
  import spk_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_MIX} state_t;

  state_t state_r;
  word_t  key_r [4];
  word_t  y_r, k_r, l1_r, l2_r;
  word_t  xs_r, ls_r;
  logic [BIT_W-1:0] bit_r;
  logic [RND_W-1:0] rnd_r;
  logic   out_valid_r;
  word_t  cw0_r, cw1_r;
  logic   sx, sl, add_clr, add_en;
  word_t  x_new, l_new;

  // serial sum: rotr(x,8)+y xor k, low bit first; same for schedule word
  spk_add_serial u_add_x (
    .clk (clk), .clr (add_clr), .en (add_en),
    .a (xs_r[0]), .b (y_r[bit_r]), .k (k_r[bit_r]), .s (sx)
  );
  spk_add_serial u_add_l (
    .clk (clk), .clr (add_clr), .en (add_en),
    .a (ls_r[0]), .b (k_r[bit_r]), .k (bit_r < BIT_W'(RND_W) ? rnd_r[bit_r[2:0]] : 1'b0),
    .s (sl)
  );

  assign add_clr = (state_r != S_ADD);
  assign add_en  = (state_r == S_ADD);
  assign x_new   = {sx, xs_r[WORD_W-1:1]};
  assign l_new   = {sl, ls_r[WORD_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
      rnd_r       <= '0;
      key_r       <= '{default: '0};
    end else begin
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_data;
      end
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            y_r     <= in_plain_word_1;
            xs_r    <= {in_plain_word_0[7:0], in_plain_word_0[WORD_W-1:8]};
            k_r     <= key_r[REG_KEY0];
            ls_r    <= {key_r[REG_KEY1][7:0], key_r[REG_KEY1][WORD_W-1:8]};
            l1_r    <= key_r[REG_KEY2];
            l2_r    <= key_r[REG_KEY3];
            bit_r   <= '0;
            rnd_r   <= '0;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          xs_r  <= x_new;
          ls_r  <= l_new;
          bit_r <= bit_r + 1'b1;
          if (bit_r == BIT_W'(WORD_W-1)) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          // xs_r / ls_r now hold the new x and new l
          y_r  <= {y_r[WORD_W-4:0], y_r[WORD_W-1:WORD_W-3]} ^ xs_r;
          k_r  <= {k_r[WORD_W-4:0], k_r[WORD_W-1:WORD_W-3]} ^ ls_r;
          l1_r <= l2_r;
          l2_r <= ls_r;
          xs_r <= {xs_r[7:0], xs_r[WORD_W-1:8]};
          ls_r <= {l1_r[7:0], l1_r[WORD_W-1:8]};
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == RND_W'(ROUNDS-1)) begin
            cw0_r       <= xs_r;
            cw1_r       <= {y_r[WORD_W-4:0], y_r[WORD_W-1:WORD_W-3]} ^ xs_r;
            out_valid_r <= 1'b1;
            rnd_r       <= '0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_ADD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cipher_word_0 = cw0_r;
  assign out_cipher_word_1 = cw1_r;

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPLY(a_valid_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPLY(a_rnd_range, clk, rst_n, busy, rnd_r < RND_W'(ROUNDS))
endmodule

@@ src/spk_add_serial.sv @@
// bit-serial add with xor of a second serial stream, carry held between beats
// depends on spk_pkg
`timescale 1ns / 1ps
module spk_add_serial (
  input  logic clk,
  input  logic clr,
  input  logic en,
  input  logic a,
  input  logic b,
  input  logic k,
  output logic s
);
  import spk_pkg::*;
  logic carry_r, carry_nxt;
  assign s         = a ^ b ^ carry_r ^ k;
  assign carry_nxt = (a & b) | (a & carry_r) | (b & carry_r);
  always_ff @(posedge clk) begin
    if (clr) begin
      carry_r <= 1'b0;
    end else if (en) begin
      carry_r <= carry_nxt;
    end
  end
endmodule
